FILE: rtl/joint_histogram_edge_search_macros.svh
// assertion macros shared by the joint histogram checkers
`ifndef JOINT_HISTOGRAM_EDGE_SEARCH_MACROS_SVH
`define JOINT_HISTOGRAM_EDGE_SEARCH_MACROS_SVH

// same-cycle implication, off while reset is high
`define JHES_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("joint histogram check failed");

// next-cycle implication, off while reset is high
`define JHES_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("joint histogram check failed");

// next-cycle implication that also holds across reset
`define JHES_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("joint histogram check failed");

`endif

FILE: rtl/jhes_pkg.sv
// shared constants and types of the joint histogram block
package jhes_pkg;

  localparam int MAX_BINS_DEF = 64;

  localparam int VAL_W    = 34;  // mapped value, q26.8
  localparam int EDGE_W   = 32;
  localparam int SAMPLE_W = 16;
  localparam int SCALE_W  = 16;
  localparam int IDX_W    = 7;
  localparam int COUNT_W  = 32;
  localparam int OBIN_W   = 6;
  localparam int NBINS_W  = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W    = 32;

  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_EDGE_A = 2'd1;
  localparam logic [1:0] MODE_EDGE_B = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_BINS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_A  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_B  = 3'd4;

  localparam logic [NBINS_W-1:0] NUM_BINS_RST = 7'd64;
  localparam logic [SCALE_W-1:0] SCALE_RST    = 16'd256;

  // edge load broadcast to the cell row
  typedef struct packed {
    logic              en_a;
    logic              en_b;
    logic [IDX_W-1:0]  index;
    logic [EDGE_W-1:0] value;
  } edge_wr_t;

  // search packet handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             ge_a;
    logic             ge_b;
    logic             found_a;
    logic             found_b;
    logic [VAL_W-1:0] val_a;
    logic [VAL_W-1:0] val_b;
  } chain_pkt_t;

endpackage

FILE: rtl/jhes_ram.sv
// generic single-port-write, registered-read ram
module jhes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/jhes_cell.sv
// one edge cell: holds edge IDX of both axes and tests the passing packet
module jhes_cell #(
  parameter int IDX      = 0,
  parameter int MAX_BINS = jhes_pkg::MAX_BINS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [$clog2(MAX_BINS+1)-1:0]    active,
  input  jhes_pkg::edge_wr_t               wr,
  input  jhes_pkg::chain_pkt_t             pkt_i,
  input  logic [$clog2(MAX_BINS)-1:0]      bin_a_i,
  input  logic [$clog2(MAX_BINS)-1:0]      bin_b_i,
  output jhes_pkg::chain_pkt_t             pkt_o,
  output logic [$clog2(MAX_BINS)-1:0]      bin_a_o,
  output logic [$clog2(MAX_BINS)-1:0]      bin_b_o
);

  localparam int CNT_W = $clog2(MAX_BINS + 1);
  localparam int BIN_W = $clog2(MAX_BINS);
  localparam int PREV  = (IDX > 0) ? IDX - 1 : 0;

  logic [jhes_pkg::EDGE_W-1:0] edge_a;
  logic [jhes_pkg::EDGE_W-1:0] edge_b;
  logic                        ge_a;
  logic                        ge_b;
  logic                        bin_ok;
  logic                        here_a;
  logic                        here_b;

  // value >= own edge; the previous cell's result comes in the packet
  assign ge_a = $signed(pkt_i.val_a) >=
                $signed({{(jhes_pkg::VAL_W-jhes_pkg::EDGE_W){edge_a[jhes_pkg::EDGE_W-1]}},
                         edge_a});
  assign ge_b = $signed(pkt_i.val_b) >=
                $signed({{(jhes_pkg::VAL_W-jhes_pkg::EDGE_W){edge_b[jhes_pkg::EDGE_W-1]}},
                         edge_b});

  // bin PREV spans edge PREV to edge IDX
  assign bin_ok = (IDX > 0) && (CNT_W'(PREV) < active);
  assign here_a = bin_ok && pkt_i.ge_a && !ge_a && !pkt_i.found_a;
  assign here_b = bin_ok && pkt_i.ge_b && !ge_b && !pkt_i.found_b;

  always_ff @(posedge clk) begin
    if (wr.en_a && (32'(wr.index) == 32'(IDX))) begin
      edge_a <= wr.value;
    end
    if (wr.en_b && (32'(wr.index) == 32'(IDX))) begin
      edge_b <= wr.value;
    end
    pkt_o.ge_a    <= ge_a;
    pkt_o.ge_b    <= ge_b;
    pkt_o.found_a <= pkt_i.found_a || here_a;
    pkt_o.found_b <= pkt_i.found_b || here_b;
    pkt_o.val_a   <= pkt_i.val_a;
    pkt_o.val_b   <= pkt_i.val_b;
    bin_a_o       <= here_a ? BIN_W'(PREV) : bin_a_i;
    bin_b_o       <= here_b ? BIN_W'(PREV) : bin_b_i;
    if (rst) begin
      pkt_o.valid <= 1'b0;
    end else begin
      pkt_o.valid <= pkt_i.valid;
    end
  end

endmodule

FILE: rtl/joint_histogram_edge_search.sv
// joint histogram top level: control, mapping, edge cell row and count ram
//
// channel  dir  handshake            payload
// in       in   in_valid/in_ready    mode sample_a sample_b index_a index_b
//                                    edge_value clear_after_read
// out      out  out_valid/out_ready  count hit bin_a bin_b
// cfg      in   cfg_we               cfg_index cfg_data
//
// one item at a time. a sample pair steps from accept through the multiply, add,
// inject and search states while its packet walks the MAX_BINS + 1 edge cells,
// then reads and updates its count ram cell unless it misses; a count read passes
// the read and update states, and an edge load goes straight to the output state.
// after reset all MAX_BINS * MAX_BINS count ram cells are cleared with in_ready
// low. a finished result waits in the output register while the next item is
// accepted; a stalled output holds the following result back.
module joint_histogram_edge_search #(
  parameter int MAX_BINS = jhes_pkg::MAX_BINS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          mode,
  input  logic signed [jhes_pkg::SAMPLE_W-1:0] sample_a,
  input  logic signed [jhes_pkg::SAMPLE_W-1:0] sample_b,
  input  logic [jhes_pkg::IDX_W-1:0]          index_a,
  input  logic [5:0]                          index_b,
  input  logic signed [jhes_pkg::EDGE_W-1:0]  edge_value,
  input  logic                                clear_after_read,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [jhes_pkg::COUNT_W-1:0]        count,
  output logic                                hit,
  output logic [jhes_pkg::OBIN_W-1:0]         bin_a,
  output logic [jhes_pkg::OBIN_W-1:0]         bin_b,
  input  logic                                cfg_we,
  input  logic [jhes_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jhes_pkg::CFG_W-1:0]          cfg_data
);

  localparam int CNT_W  = $clog2(MAX_BINS + 1);
  localparam int BIN_W  = $clog2(MAX_BINS);
  localparam int DEPTH  = MAX_BINS * MAX_BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int NCELL  = MAX_BINS + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL, S_ADD, S_INJECT, S_SEARCH, S_RD, S_RMW, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [jhes_pkg::NBINS_W-1:0]        num_bins;
  logic signed [jhes_pkg::EDGE_W-1:0]  offset_a;
  logic signed [jhes_pkg::SCALE_W-1:0] scale_a;
  logic signed [jhes_pkg::EDGE_W-1:0]  offset_b;
  logic signed [jhes_pkg::SCALE_W-1:0] scale_b;
  logic [CNT_W-1:0]                    active;

  // item in flight
  logic [1:0]                           lat_mode;
  logic signed [jhes_pkg::SAMPLE_W-1:0] lat_sa;
  logic signed [jhes_pkg::SAMPLE_W-1:0] lat_sb;
  logic                                 lat_clear;
  logic                                 rd_ok;
  logic signed [31:0]                   prod_a;
  logic signed [31:0]                   prod_b;
  logic signed [jhes_pkg::VAL_W-1:0]    val_a;
  logic signed [jhes_pkg::VAL_W-1:0]    val_b;
  logic [ADDR_W-1:0]                    cell_addr;
  logic [ADDR_W-1:0]                    clr_addr;

  // pending result
  logic [jhes_pkg::COUNT_W-1:0] res_count;
  logic                         res_hit;
  logic [BIN_W-1:0]             res_bin_a;
  logic [BIN_W-1:0]             res_bin_b;

  // count ram
  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_waddr;
  logic [jhes_pkg::COUNT_W-1:0] ram_wdata;
  logic [jhes_pkg::COUNT_W-1:0] ram_rdata;
  logic [jhes_pkg::COUNT_W-1:0] inc_count;

  // cell row
  jhes_pkg::edge_wr_t   ewr;
  jhes_pkg::chain_pkt_t pkt [0:NCELL];
  logic [BIN_W-1:0]     cba [0:NCELL];
  logic [BIN_W-1:0]     cbb [0:NCELL];

  logic accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign active = (32'(num_bins) > 32'(MAX_BINS)) ? CNT_W'(MAX_BINS) : CNT_W'(num_bins);

  assign ewr.en_a  = accept && (mode == jhes_pkg::MODE_EDGE_A);
  assign ewr.en_b  = accept && (mode == jhes_pkg::MODE_EDGE_B);
  assign ewr.index = index_a;
  assign ewr.value = edge_value;

  assign pkt[0].valid   = (state == S_INJECT);
  assign pkt[0].ge_a    = 1'b0;
  assign pkt[0].ge_b    = 1'b0;
  assign pkt[0].found_a = 1'b0;
  assign pkt[0].found_b = 1'b0;
  assign pkt[0].val_a   = val_a;
  assign pkt[0].val_b   = val_b;
  assign cba[0]         = '0;
  assign cbb[0]         = '0;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    jhes_cell #(
      .IDX      (g),
      .MAX_BINS (MAX_BINS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .active  (active),
      .wr      (ewr),
      .pkt_i   (pkt[g]),
      .bin_a_i (cba[g]),
      .bin_b_i (cbb[g]),
      .pkt_o   (pkt[g+1]),
      .bin_a_o (cba[g+1]),
      .bin_b_o (cbb[g+1])
    );
  end

  // saturating increment of the cell just read
  assign inc_count = (ram_rdata == '1) ? ram_rdata : ram_rdata + 32'd1;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_addr;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
    end else if (state == S_RMW) begin
      if (lat_mode == jhes_pkg::MODE_SAMPLE) begin
        ram_we    = 1'b1;
        ram_wdata = inc_count;
      end else begin
        ram_we = rd_ok && lat_clear;
      end
    end
  end

  jhes_ram #(
    .WIDTH (jhes_pkg::COUNT_W),
    .DEPTH (DEPTH)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cell_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      num_bins  <= jhes_pkg::NUM_BINS_RST;
      offset_a  <= '0;
      scale_a   <= jhes_pkg::SCALE_RST;
      offset_b  <= '0;
      scale_b   <= jhes_pkg::SCALE_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          jhes_pkg::REG_NUM_BINS: num_bins <= cfg_data[jhes_pkg::NBINS_W-1:0];
          jhes_pkg::REG_OFFSET_A: offset_a <= cfg_data;
          jhes_pkg::REG_SCALE_A:  scale_a  <= cfg_data[jhes_pkg::SCALE_W-1:0];
          jhes_pkg::REG_OFFSET_B: offset_b <= cfg_data;
          jhes_pkg::REG_SCALE_B:  scale_b  <= cfg_data[jhes_pkg::SCALE_W-1:0];
          default: ;
        endcase
      end

      // in S_OUT the result load below decides out_valid
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            lat_mode  <= mode;
            lat_sa    <= sample_a;
            lat_sb    <= sample_b;
            lat_clear <= clear_after_read;
            res_count <= '0;
            res_hit   <= 1'b0;
            res_bin_a <= '0;
            res_bin_b <= '0;
            rd_ok     <= (32'(index_a) < 32'(MAX_BINS)) && (32'(index_b) < 32'(MAX_BINS));
            cell_addr <= ADDR_W'(ADDR_W'(index_a) * ADDR_W'(MAX_BINS) + ADDR_W'(index_b));
            unique case (mode)
              jhes_pkg::MODE_SAMPLE: state <= S_MUL;
              jhes_pkg::MODE_EDGE_A: state <= S_OUT;
              jhes_pkg::MODE_EDGE_B: state <= S_OUT;
              jhes_pkg::MODE_READ:   state <= S_RD;
            endcase
          end
        end
        S_MUL: begin
          prod_a <= lat_sa * scale_a;
          prod_b <= lat_sb * scale_b;
          state  <= S_ADD;
        end
        S_ADD: begin
          val_a <= jhes_pkg::VAL_W'(offset_a) + jhes_pkg::VAL_W'(prod_a);
          val_b <= jhes_pkg::VAL_W'(offset_b) + jhes_pkg::VAL_W'(prod_b);
          state <= S_INJECT;
        end
        S_INJECT: begin
          state <= S_SEARCH;
        end
        S_SEARCH: begin
          if (pkt[NCELL].valid) begin
            if (pkt[NCELL].found_a && pkt[NCELL].found_b) begin
              res_bin_a <= cba[NCELL];
              res_bin_b <= cbb[NCELL];
              cell_addr <= ADDR_W'(ADDR_W'(cba[NCELL]) * ADDR_W'(MAX_BINS)
                                   + ADDR_W'(cbb[NCELL]));
              state     <= S_RD;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_RD: begin
          state <= S_RMW;
        end
        S_RMW: begin
          if (lat_mode == jhes_pkg::MODE_SAMPLE) begin
            res_count <= inc_count;
            res_hit   <= 1'b1;
          end else begin
            res_count <= rd_ok ? ram_rdata : '0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            count     <= res_count;
            hit       <= res_hit;
            bin_a     <= jhes_pkg::OBIN_W'(res_bin_a);
            bin_b     <= jhes_pkg::OBIN_W'(res_bin_b);
            state     <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

endmodule

FILE: rtl/jhes_checker.sv
// port-level checks of the joint histogram block and their binding
`include "joint_histogram_edge_search_macros.svh"

module jhes_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] count,
  input logic        hit,
  input logic [5:0]  bin_a,
  input logic [5:0]  bin_b
);

  // a hit reports the count after its increment, so never zero
  `JHES_ASSERT_IMPL(a_hit_nonzero, out_valid && hit, count != 32'd0)
  // results without a hit carry no bins
  `JHES_ASSERT_IMPL(a_miss_no_bins, out_valid && !hit, bin_a == 6'd0 && bin_b == 6'd0)
  // one item at a time
  `JHES_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
  // count ram clearing keeps the input closed after reset
  `JHES_ASSERT_ALWAYS(a_reset_closed, rst, !in_ready && !out_valid)
  `JHES_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(count) && $stable(hit))

endmodule

bind joint_histogram_edge_search jhes_checker u_jhes_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .count     (count),
  .hit       (hit),
  .bin_a     (bin_a),
  .bin_b     (bin_b)
);

FILE: test/testbench.sv
// self-checking testbench for the joint histogram edge search block
module testbench;

  localparam int MAX_BINS = jhes_pkg::MAX_BINS_DEF;
  localparam int CELLS = MAX_BINS * MAX_BINS;
  localparam int WATCHDOG_LIMIT = 4 * CELLS + 1000;
  localparam longint EDGE_MAX = 64'sd2147483647;
  localparam longint EDGE_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [1:0]                    mode;
    logic [jhes_pkg::SAMPLE_W-1:0] sample_a;
    logic [jhes_pkg::SAMPLE_W-1:0] sample_b;
    logic [jhes_pkg::IDX_W-1:0]    index_a;
    logic [5:0]                    index_b;
    logic [jhes_pkg::EDGE_W-1:0]   edge_value;
    logic                          clear_after_read;
  } hist_cmd_t;

  typedef struct packed {
    logic [jhes_pkg::COUNT_W-1:0] count;
    logic                         hit;
    logic [jhes_pkg::OBIN_W-1:0]  bin_a;
    logic [jhes_pkg::OBIN_W-1:0]  bin_b;
  } bin_result_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] mode = jhes_pkg::MODE_SAMPLE;
  logic signed [jhes_pkg::SAMPLE_W-1:0] sample_a = '0;
  logic signed [jhes_pkg::SAMPLE_W-1:0] sample_b = '0;
  logic [jhes_pkg::IDX_W-1:0] index_a = '0;
  logic [5:0] index_b = '0;
  logic signed [jhes_pkg::EDGE_W-1:0] edge_value = '0;
  logic clear_after_read = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [jhes_pkg::COUNT_W-1:0] count;
  logic hit;
  logic [jhes_pkg::OBIN_W-1:0] bin_a;
  logic [jhes_pkg::OBIN_W-1:0] bin_b;
  logic cfg_we = 1'b0;
  logic [jhes_pkg::CFG_IDX_W-1:0] cfg_index = jhes_pkg::REG_NUM_BINS;
  logic [jhes_pkg::CFG_W-1:0] cfg_data = '0;

  // shadow of the block's state and registers
  logic signed [jhes_pkg::EDGE_W-1:0] edge_tbl_a [0:MAX_BINS];
  logic signed [jhes_pkg::EDGE_W-1:0] edge_tbl_b [0:MAX_BINS];
  logic [jhes_pkg::COUNT_W-1:0] hist_cells [CELLS] = '{default: '0};
  logic [jhes_pkg::NBINS_W-1:0] bins_used = jhes_pkg::NUM_BINS_RST;
  logic signed [jhes_pkg::EDGE_W-1:0] offset_a_q = '0;
  logic signed [jhes_pkg::SCALE_W-1:0] scale_a_q = jhes_pkg::SCALE_RST;
  logic signed [jhes_pkg::EDGE_W-1:0] offset_b_q = '0;
  logic signed [jhes_pkg::SCALE_W-1:0] scale_b_q = jhes_pkg::SCALE_RST;

  bin_result_t pending_results[$];
  bin_result_t want;
  int mismatches = 0;
  bit no_idle = 1'b0;
  int lo_a, pitch_a, lo_b, pitch_b;
  logic [5:0] last_row = '0;
  logic [5:0] last_col = '0;

  joint_histogram_edge_search #(.MAX_BINS(MAX_BINS)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .sample_a(sample_a), .sample_b(sample_b),
    .index_a(index_a), .index_b(index_b), .edge_value(edge_value),
    .clear_after_read(clear_after_read),
    .out_valid(out_valid), .out_ready(out_ready),
    .count(count), .hit(hit), .bin_a(bin_a), .bin_b(bin_b),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // first bin whose edge pair brackets the mapped value, -1 for none
  function automatic int locate_bin(input bit axis_b, input longint v);
    int lim;
    longint lo, hi;
    lim = (bins_used > MAX_BINS) ? MAX_BINS : int'(bins_used);
    for (int i = 0; i < lim; i++) begin
      if (axis_b) begin
        lo = edge_tbl_b[i];
        hi = edge_tbl_b[i + 1];
      end else begin
        lo = edge_tbl_a[i];
        hi = edge_tbl_a[i + 1];
      end
      if (v >= lo && v < hi) return i;
    end
    return -1;
  endfunction

  function automatic bin_result_t histogram_update(input hist_cmd_t c);
    bin_result_t r;
    longint sa, sb, va, vb;
    int row, col, k;
    r = '0;
    case (c.mode)
      jhes_pkg::MODE_SAMPLE: begin
        sa = $signed(c.sample_a);
        sb = $signed(c.sample_b);
        va = longint'(offset_a_q) + sa * longint'(scale_a_q);
        vb = longint'(offset_b_q) + sb * longint'(scale_b_q);
        row = locate_bin(1'b0, va);
        col = locate_bin(1'b1, vb);
        if (row >= 0 && col >= 0) begin
          k = row * MAX_BINS + col;
          if (hist_cells[k] != '1) hist_cells[k] = hist_cells[k] + 1;
          r.count = hist_cells[k];
          r.hit = 1'b1;
          r.bin_a = row[jhes_pkg::OBIN_W-1:0];
          r.bin_b = col[jhes_pkg::OBIN_W-1:0];
          last_row = row[5:0];
          last_col = col[5:0];
        end
      end
      jhes_pkg::MODE_EDGE_A, jhes_pkg::MODE_EDGE_B: begin
        if (c.index_a <= MAX_BINS) begin
          if (c.mode == jhes_pkg::MODE_EDGE_A) edge_tbl_a[c.index_a] = c.edge_value;
          else edge_tbl_b[c.index_a] = c.edge_value;
        end
      end
      default: begin
        if (c.index_a < MAX_BINS && c.index_b < MAX_BINS) begin
          k = int'(c.index_a) * MAX_BINS + int'(c.index_b);
          r.count = hist_cells[k];
          if (c.clear_after_read) hist_cells[k] = '0;
        end
      end
    endcase
    return r;
  endfunction

  function automatic hist_cmd_t random_cmd();
    hist_cmd_t c;
    c.mode = jhes_pkg::MODE_SAMPLE;
    c.sample_a = jhes_pkg::SAMPLE_W'($urandom);
    c.sample_b = jhes_pkg::SAMPLE_W'($urandom);
    c.index_a = jhes_pkg::IDX_W'($urandom);
    c.index_b = 6'($urandom);
    c.edge_value = $urandom;
    c.clear_after_read = 1'($urandom);
    return c;
  endfunction

  function automatic hist_cmd_t sample_cmd(input bit on_grid);
    hist_cmd_t c;
    c = random_cmd();
    c.mode = jhes_pkg::MODE_SAMPLE;
    if (on_grid) begin
      c.sample_a = jhes_pkg::SAMPLE_W'(lo_a + int'($urandom_range(0, MAX_BINS * pitch_a)));
      c.sample_b = jhes_pkg::SAMPLE_W'(lo_b + int'($urandom_range(0, MAX_BINS * pitch_b)));
    end
    return c;
  endfunction

  function automatic hist_cmd_t read_cmd();
    hist_cmd_t c;
    c = random_cmd();
    c.mode = jhes_pkg::MODE_READ;
    case ($urandom_range(0, 3))
      0, 1: begin
        c.index_a = {1'b0, last_row};
        c.index_b = last_col;
      end
      2: c.index_a = jhes_pkg::IDX_W'($urandom_range(0, MAX_BINS - 1));
      default: ;  // any index, often out of range
    endcase
    return c;
  endfunction

  // nudges an existing edge, or writes anywhere above the table
  function automatic hist_cmd_t edge_cmd();
    hist_cmd_t c;
    c = random_cmd();
    c.mode = $urandom_range(0, 1) ? jhes_pkg::MODE_EDGE_B : jhes_pkg::MODE_EDGE_A;
    if (c.index_a <= MAX_BINS) begin
      if (c.mode == jhes_pkg::MODE_EDGE_A) c.edge_value = edge_tbl_a[c.index_a];
      else c.edge_value = edge_tbl_b[c.index_a];
      c.edge_value = c.edge_value + jhes_pkg::EDGE_W'($urandom_range(0, 512)) - 32'd256;
    end
    return c;
  endfunction

  task automatic send_item(input hist_cmd_t c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= c.mode;
    sample_a <= c.sample_a;
    sample_b <= c.sample_b;
    index_a <= c.index_a;
    index_b <= c.index_b;
    edge_value <= c.edge_value;
    clear_after_read <= c.clear_after_read;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(histogram_update(c));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [jhes_pkg::CFG_IDX_W-1:0] idx,
                           input logic [jhes_pkg::CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      jhes_pkg::REG_NUM_BINS: bins_used = data[jhes_pkg::NBINS_W-1:0];
      jhes_pkg::REG_OFFSET_A: offset_a_q = data;
      jhes_pkg::REG_SCALE_A:  scale_a_q = data[jhes_pkg::SCALE_W-1:0];
      jhes_pkg::REG_OFFSET_B: offset_b_q = data;
      jhes_pkg::REG_SCALE_B:  scale_b_q = data[jhes_pkg::SCALE_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mapping(input logic [jhes_pkg::NBINS_W-1:0] nb,
                             input logic [jhes_pkg::EDGE_W-1:0] oa,
                             input logic [jhes_pkg::SCALE_W-1:0] sa,
                             input logic [jhes_pkg::EDGE_W-1:0] ob,
                             input logic [jhes_pkg::SCALE_W-1:0] sb);
    wait_for_results();
    write_reg(jhes_pkg::REG_NUM_BINS, jhes_pkg::CFG_W'(nb));
    write_reg(jhes_pkg::REG_OFFSET_A, oa);
    write_reg(jhes_pkg::REG_SCALE_A, jhes_pkg::CFG_W'(sa));
    write_reg(jhes_pkg::REG_OFFSET_B, ob);
    write_reg(jhes_pkg::REG_SCALE_B, jhes_pkg::CFG_W'(sb));
  endtask

  // loads a full edge table so that samples lo, lo+pitch, ... land on bin edges
  task automatic place_edges(input bit axis_b, input int lo, input int pitch);
    hist_cmd_t c;
    longint ofs, scl, v;
    if (axis_b) begin
      ofs = offset_b_q;
      scl = scale_b_q;
      lo_b = lo;
      pitch_b = pitch;
    end else begin
      ofs = offset_a_q;
      scl = scale_a_q;
      lo_a = lo;
      pitch_a = pitch;
    end
    for (int i = 0; i <= MAX_BINS; i++) begin
      v = ofs + longint'(lo + i * pitch) * scl;
      if (v > EDGE_MAX) v = EDGE_MAX;
      if (v < EDGE_MIN) v = EDGE_MIN;
      c = random_cmd();
      c.mode = axis_b ? jhes_pkg::MODE_EDGE_B : jhes_pkg::MODE_EDGE_A;
      // a negative gain flips the order of the mapped values
      c.index_a = jhes_pkg::IDX_W'((scl < 0) ? MAX_BINS - i : i);
      c.edge_value = jhes_pkg::EDGE_W'(v);
      send_item(c);
    end
  endtask

  task automatic send_pair(input int sa, input int sb);
    hist_cmd_t c;
    c = random_cmd();
    c.mode = jhes_pkg::MODE_SAMPLE;
    c.sample_a = jhes_pkg::SAMPLE_W'(sa);
    c.sample_b = jhes_pkg::SAMPLE_W'(sb);
    send_item(c);
  endtask

  task automatic send_read(input int ia, input int ib, input bit clr);
    hist_cmd_t c;
    c = random_cmd();
    c.mode = jhes_pkg::MODE_READ;
    c.index_a = jhes_pkg::IDX_W'(ia);
    c.index_b = 6'(ib);
    c.clear_after_read = clr;
    send_item(c);
  endtask

  task automatic send_edge(input logic [1:0] m, input int idx,
                           input logic [jhes_pkg::EDGE_W-1:0] val);
    hist_cmd_t c;
    c = random_cmd();
    c.mode = m;
    c.index_a = jhes_pkg::IDX_W'(idx);
    c.edge_value = val;
    send_item(c);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) send_item(sample_cmd(1'b1));
    else if (r < 78) send_item(sample_cmd(1'b0));
    else if (r < 90) send_item(read_cmd());
    else if (r < 97) send_item(edge_cmd());
    else wait_for_results();
  endtask

  function automatic logic [jhes_pkg::SCALE_W-1:0] pick_scale();
    case ($urandom_range(0, 7))
      0: return jhes_pkg::SCALE_RST;
      1: return 16'hFF00;
      2: return 16'h7FFF;
      3: return 16'h8000;
      4: return 16'h0001;
      5: return 16'hFFFF;
      default: return jhes_pkg::SCALE_W'($urandom_range(0, 4096)) - 16'd2048;
    endcase
  endfunction

  function automatic logic [jhes_pkg::EDGE_W-1:0] pick_offset();
    case ($urandom_range(0, 7))
      6: return 32'h8000_0000;
      7: return 32'h7FFF_FFFF;
      default: return jhes_pkg::EDGE_W'($urandom_range(0, 1 << 25)) - 32'd16777216;
    endcase
  endfunction

  function automatic logic [jhes_pkg::NBINS_W-1:0] pick_bins();
    case ($urandom_range(0, 7))
      3: return 7'd1;
      4: return 7'd2;
      5: return 7'd63;
      6: return jhes_pkg::NBINS_W'(65 + $urandom_range(0, 62));
      7: return jhes_pkg::NBINS_W'($urandom_range(1, MAX_BINS));
      default: return jhes_pkg::NBINS_W'(MAX_BINS);
    endcase
  endfunction

  task automatic test_directed_cases();
    place_edges(1'b0, -128, 4);
    place_edges(1'b1, -64, 2);
    send_pair(-128, -64);     // both on the lowest edge
    send_pair(-128, -64);
    send_pair(128, 0);        // upper edge is exclusive
    send_pair(127, 63);
    send_pair(-129, 0);
    send_pair(-32768, 32767);
    send_pair(32767, -32768);
    send_read(0, 0, 1'b0);
    send_read(0, 0, 1'b1);
    send_read(0, 0, 1'b0);
    send_read(MAX_BINS, 0, 1'b1);  // out of range, nothing cleared
    send_read(127, 63, 1'b1);
    send_edge(jhes_pkg::MODE_EDGE_A, MAX_BINS + 1, 32'h7FFF_FFFF);  // ignored
    send_edge(jhes_pkg::MODE_EDGE_B, 127, 32'h8000_0000);
    send_edge(jhes_pkg::MODE_EDGE_A, MAX_BINS, 32'h7FFF_FFFF);
    send_pair(32767, 62);
    send_edge(jhes_pkg::MODE_EDGE_B, 0, 32'h8000_0000);
    send_pair(0, -32768);
    send_read(32, 0, 1'b1);
    send_read(63, 63, 1'b0);
  endtask

  task automatic test_bin_count_limits();
    set_mapping(7'd0, '0, jhes_pkg::SCALE_RST, '0, jhes_pkg::SCALE_RST);
    send_pair(0, 0);
    send_pair(-128, -64);
    set_mapping(7'd127, '0, jhes_pkg::SCALE_RST, '0, jhes_pkg::SCALE_RST);
    send_pair(127, 63);
    send_pair(0, 0);
    set_mapping(7'd1, '0, jhes_pkg::SCALE_RST, '0, jhes_pkg::SCALE_RST);
    send_pair(-128, -64);
    send_pair(-124, -62);
    set_mapping(7'd65, '0, jhes_pkg::SCALE_RST, '0, jhes_pkg::SCALE_RST);
    send_pair(0, 0);
    set_mapping(jhes_pkg::NBINS_W'(MAX_BINS), '0, jhes_pkg::SCALE_RST, '0,
                jhes_pkg::SCALE_RST);
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (120) random_item();
    no_idle = 1'b0;
  endtask

  task automatic test_mapping_extremes();
    set_mapping(jhes_pkg::NBINS_W'(MAX_BINS), 32'h8000_0000, 16'h8000, 32'h7FFF_FFFF,
                16'h7FFF);
    place_edges(1'b0, -32768, 1023);
    place_edges(1'b1, -32768, 1023);
    send_pair(-32768, 32767);
    send_pair(32767, -32768);
    repeat (12) send_item(sample_cmd(1'($urandom_range(0, 1))));
    set_mapping(7'd2, 32'h7FFF_FFFF, 16'h8000, 32'h8000_0000, 16'h7FFF);
    place_edges(1'b0, -32768, 1023);
    place_edges(1'b1, -32768, 1023);
    send_pair(-32768, -32768);
    send_pair(32767, 32767);
    repeat (12) send_item(sample_cmd(1'($urandom_range(0, 1))));
    // zero gain maps every sample onto the offset
    set_mapping(jhes_pkg::NBINS_W'(MAX_BINS), '0, '0, '0, '0);
    repeat (6) send_item(sample_cmd(1'b1));
  endtask

  task automatic test_random_phases();
    int pa, pb;
    for (int p = 0; p < 4; p++) begin
      set_mapping(pick_bins(), pick_offset(), pick_scale(), pick_offset(), pick_scale());
      pa = $urandom_range(1, 1023);
      pb = $urandom_range(1, 1023);
      place_edges(1'b0, -32768 + int'($urandom_range(0, 65535 - MAX_BINS * pa)), pa);
      place_edges(1'b1, -32768 + int'($urandom_range(0, 65535 - MAX_BINS * pb)), pb);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (120) random_item();
      no_idle = 1'b0;
    end
  endtask

  function automatic void note_mismatch(input string field, input longint exp_v,
                                        input longint got_v);
    $error("%s: expected %0d, got %0d", field, exp_v, got_v);
    mismatches++;
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected item count", -1, count);
      end else begin
        want = pending_results.pop_front();
        if (count !== want.count) note_mismatch("count", want.count, count);
        if (hit !== want.hit) note_mismatch("hit", want.hit, hit);
        if (bin_a !== want.bin_a) note_mismatch("bin_a", want.bin_a, bin_a);
        if (bin_b !== want.bin_b) note_mismatch("bin_b", want.bin_b, bin_b);
      end
    end
  end

  initial begin : drive_out_ready
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  // covers the count ram clearing pass after reset
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("testbench failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_bin_count_limits();
    test_back_to_back();
    test_mapping_extremes();
    test_random_phases();
    wait_for_results();
    repeat (MAX_BINS + 16) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/jhes_pkg.sv
rtl/jhes_ram.sv
rtl/jhes_cell.sv
rtl/joint_histogram_edge_search.sv
rtl/jhes_checker.sv
test/testbench.sv
